// ----- rtl/crow_pkg.sv -----
// Shared constants for the CIGAR reference offset walker.
`default_nettype none
package crow_pkg;

  // Fixed field widths
  localparam int CHAR_W   = 8;
  localparam int TARGET_W = 20;
  localparam int SHIFT_W  = 21;

  // Largest magnitude of the reported indel shift
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 21'd1048575;

  // CIGAR character codes
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_SOFT = 8'h53;  // 'S'
  localparam logic [CHAR_W-1:0] CH_MAT  = 8'h4D;  // 'M'
  localparam logic [CHAR_W-1:0] CH_DEL  = 8'h44;  // 'D'
  localparam logic [CHAR_W-1:0] CH_INS  = 8'h49;  // 'I'

endpackage
`default_nettype wire

// ----- rtl/cigar_reference_offset_walker.sv -----
// Last character path: input register, then result register, then out_valid.
// Throughput: one character request per cycle; the input register stalls only
// when a last character finds the result register full and not being taken.
// The walk state (run, totals, flags) updates once per character.
// Reset: synchronous, active low; clears both valid flags and all walk state.
`default_nettype none
module cigar_reference_offset_walker
  import crow_pkg::*;
#(
  parameter int COUNT_WIDTH = 20
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [CHAR_W-1:0]        in_cigar_char,
  input  wire  [TARGET_W-1:0]      in_target_offset,
  input  wire                      in_last_char,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [SHIFT_W-1:0] out_indel_shift,
  output logic                     out_in_deletion,
  output logic                     out_bad_char_seen
);

  localparam int CW   = COUNT_WIDTH;
  localparam int MW   = CW + 4;
  localparam int CMPW = (CW + 1 > TARGET_W) ? CW + 1 : TARGET_W;
  localparam int DW   = (CW + 1 > SHIFT_W + 1) ? CW + 1 : SHIFT_W + 1;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  // Input register
  logic                s0_valid_r;
  logic [CHAR_W-1:0]   s0_char_r;
  logic [TARGET_W-1:0] s0_target_r;
  logic                s0_last_r;
  logic                s0_fire;

  // Walk state
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] match_r, match_nxt;
  logic [CW-1:0] del_r, del_nxt;
  logic [CW-1:0] ins_r, ins_nxt;
  logic          stopped_r, stopped_nxt;
  logic          on_del_r, on_del_nxt;
  logic          bad_r, bad_nxt;

  // Result register
  logic                      out_valid_r;
  logic signed [SHIFT_W-1:0] shift_r, shift_nxt;
  logic                      res_del_r;
  logic                      res_bad_r;

  logic [MW-1:0]   run_x10;
  logic [CW:0]     sum_add;
  logic [CW-1:0]   add_sat;
  logic [CW:0]     consumed;
  logic            reached;
  logic signed [DW-1:0] diff;

  // Advance the input stage unless a result would collide with a held one
  assign s0_fire  = s0_valid_r && (!s0_last_r || !out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || s0_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_char_r   <= in_cigar_char;
      s0_target_r <= in_target_offset;
      s0_last_r   <= in_last_char;
    end
  end

  // Decode one character against the current walk state
  always_comb begin
    run_x10 = ({4'b0, run_r} << 3) + ({4'b0, run_r} << 1)
            + MW'(s0_char_r - CH_ZERO);
    sum_add = '0;
    if (s0_char_r == CH_MAT) begin
      sum_add = {1'b0, match_r} + {1'b0, run_r};
    end else if (s0_char_r == CH_DEL) begin
      sum_add = {1'b0, del_r} + {1'b0, run_r};
    end else begin
      sum_add = {1'b0, ins_r} + {1'b0, run_r};
    end
    add_sat = sum_add[CW] ? CMAX : sum_add[CW-1:0];

    run_nxt     = run_r;
    match_nxt   = match_r;
    del_nxt     = del_r;
    ins_nxt     = ins_r;
    stopped_nxt = stopped_r;
    on_del_nxt  = on_del_r;
    bad_nxt     = bad_r;

    if (!stopped_r) begin
      if (s0_char_r >= CH_ZERO && s0_char_r <= CH_NINE) begin
        run_nxt = (run_x10 > MW'(CMAX)) ? CMAX : run_x10[CW-1:0];
      end else if (s0_char_r == CH_SOFT) begin
        run_nxt = '0;
      end else if (s0_char_r == CH_MAT) begin
        match_nxt = add_sat;
        run_nxt   = '0;
      end else if (s0_char_r == CH_DEL) begin
        del_nxt = add_sat;
        run_nxt = '0;
      end else if (s0_char_r == CH_INS) begin
        ins_nxt = add_sat;
        run_nxt = '0;
      end else begin
        bad_nxt = 1'b1;
      end
    end

    // Check reference bases consumed against the target after M or D
    consumed = {1'b0, match_nxt} + {1'b0, del_nxt};
    reached  = CMPW'(consumed) >= CMPW'(s0_target_r);
    if (!stopped_r && (s0_char_r == CH_MAT || s0_char_r == CH_DEL) && reached) begin
      stopped_nxt = 1'b1;
      on_del_nxt  = (s0_char_r == CH_DEL);
    end

    // Clamp deletions minus insertions; zero when stopped in a deletion
    diff = DW'($signed({1'b0, del_nxt})) - DW'($signed({1'b0, ins_nxt}));
    if (on_del_nxt) begin
      shift_nxt = '0;
    end else if (diff > $signed(DW'(SHIFT_LIMIT))) begin
      shift_nxt = $signed(SHIFT_LIMIT);
    end else if (diff < -$signed(DW'(SHIFT_LIMIT))) begin
      shift_nxt = -$signed(SHIFT_LIMIT);
    end else begin
      shift_nxt = diff[SHIFT_W-1:0];
    end
  end

  // Update walk state; drop it back to zero after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= '0;
      match_r   <= '0;
      del_r     <= '0;
      ins_r     <= '0;
      stopped_r <= 1'b0;
      on_del_r  <= 1'b0;
      bad_r     <= 1'b0;
    end else if (s0_fire) begin
      if (s0_last_r) begin
        run_r     <= '0;
        match_r   <= '0;
        del_r     <= '0;
        ins_r     <= '0;
        stopped_r <= 1'b0;
        on_del_r  <= 1'b0;
        bad_r     <= 1'b0;
      end else begin
        run_r     <= run_nxt;
        match_r   <= match_nxt;
        del_r     <= del_nxt;
        ins_r     <= ins_nxt;
        stopped_r <= stopped_nxt;
        on_del_r  <= on_del_nxt;
        bad_r     <= bad_nxt;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_fire && s0_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && s0_last_r) begin
      shift_r   <= shift_nxt;
      res_del_r <= on_del_nxt;
      res_bad_r <= bad_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_indel_shift   = shift_r;
  assign out_in_deletion   = res_del_r;
  assign out_bad_char_seen = res_bad_r;

endmodule
`default_nettype wire

// ----- rtl/crow_checker.sv -----
// Port-level checks for the CIGAR reference offset walker, bound to the top level.
`default_nettype none
module crow_checker
  import crow_pkg::*;
(
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire signed [SHIFT_W-1:0] out_indel_shift,
  input wire                      out_in_deletion,
  input wire                      out_bad_char_seen
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result request holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_indel_shift)
      && $stable(out_in_deletion) && $stable(out_bad_char_seen))
    else $error("stalled result changed");

  // Target inside a deletion reports no shift
  a_del_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_deletion |-> out_indel_shift == '0)
    else $error("shift not zero inside deletion");

  // Shift stays within the clamp
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_indel_shift != {1'b1, {(SHIFT_W-1){1'b0}}})
    else $error("shift below clamp");

endmodule

bind cigar_reference_offset_walker crow_checker u_crow_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_indel_shift   (out_indel_shift),
  .out_in_deletion   (out_in_deletion),
  .out_bad_char_seen (out_bad_char_seen)
);
`default_nettype wire

// ----- bench/cigar_reference_offset_walker_test.sv -----
// Self-checking bench for the CIGAR reference offset walker: random strings, stalls, checks.
module cigar_reference_offset_walker_test;
  import crow_pkg::*;

  localparam int COUNT_W       = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PCT      = 11;
  localparam int HOLD_CYCLES   = 90;

  typedef struct {
    logic [CHAR_W-1:0]   ch;
    logic [TARGET_W-1:0] target;
    logic                last;
    bit                  drain;
  } cigar_req_t;

  typedef struct {
    logic signed [SHIFT_W-1:0] shift;
    logic                      in_del;
    logic                      bad;
  } walk_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [CHAR_W-1:0]         in_cigar_char;
  logic [TARGET_W-1:0]       in_target_offset;
  logic                      in_last_char;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [SHIFT_W-1:0] out_indel_shift;
  logic                      out_in_deletion;
  logic                      out_bad_char_seen;

  cigar_reference_offset_walker #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cigar_char    (in_cigar_char),
    .in_target_offset (in_target_offset),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_indel_shift  (out_indel_shift),
    .out_in_deletion  (out_in_deletion),
    .out_bad_char_seen(out_bad_char_seen)
  );

  always #2 clk = ~clk;

  cigar_req_t   pending_chars[$];
  walk_result_t expected_results[$];
  cigar_req_t   offered;
  bit           req_taken;

  int accepted_cnt, total_items, results_seen, error_cnt;
  int hold_left, hold_starts, strings_sent, del_hits, bad_hits, sat_runs;

  // Walk state mirrored from the block
  logic [COUNT_W-1:0] run_len, match_tot, del_tot, ins_tot;
  bit walk_stopped, walk_on_del, walk_bad;

  function automatic logic [COUNT_W-1:0] sat_sum(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

  // Stop once the reference bases consumed reach the target
  task automatic mark_reach(input logic [TARGET_W-1:0] target, input bit on_del);
    if (({1'b0, match_tot} + {1'b0, del_tot}) >= {1'b0, target}) begin
      walk_stopped = 1'b1;
      walk_on_del  = on_del;
    end
  endtask

  // Advance the walk by one character and queue the result on the last one
  task automatic walk_char(input cigar_req_t r);
    longint unsigned grown;
    walk_result_t    res;
    if (!walk_stopped) begin
      if (r.ch >= CH_ZERO && r.ch <= CH_NINE) begin
        grown = run_len;
        grown = grown * 10 + (r.ch - CH_ZERO);
        if (grown > COUNT_MAX) begin
          run_len = COUNT_MAX;
          sat_runs++;
        end else begin
          run_len = grown[COUNT_W-1:0];
        end
      end else begin
        case (r.ch)
          CH_SOFT: run_len = '0;
          CH_MAT: begin
            match_tot = sat_sum(match_tot, run_len);
            run_len   = '0;
            mark_reach(r.target, 1'b0);
          end
          CH_DEL: begin
            del_tot = sat_sum(del_tot, run_len);
            run_len = '0;
            mark_reach(r.target, 1'b1);
          end
          CH_INS: begin
            ins_tot = sat_sum(ins_tot, run_len);
            run_len = '0;
          end
          default: walk_bad = 1'b1;
        endcase
      end
    end
    if (r.last) begin
      res.in_del = walk_on_del;
      res.bad    = walk_bad;
      // Totals stay below 2^20, so the difference always fits the shift range
      res.shift  = walk_on_del ? '0 : $signed({1'b0, del_tot}) - $signed({1'b0, ins_tot});
      expected_results.insert(expected_results.size(), res);
      run_len      = '0;
      match_tot    = '0;
      del_tot      = '0;
      ins_tot      = '0;
      walk_stopped = 1'b0;
      walk_on_del  = 1'b0;
      walk_bad     = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_cnt++;
    $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // Compare one delivered result against the oldest expectation
  task automatic check_result();
    walk_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, shift", out_indel_shift, 0);
    end else begin
      want = expected_results.pop_front();
      if (want.in_del) del_hits++;
      if (want.bad) bad_hits++;
      if (out_indel_shift !== want.shift)
        report_mismatch("indel_shift", out_indel_shift, want.shift);
      if (out_in_deletion !== want.in_del)
        report_mismatch("in_deletion", out_in_deletion, want.in_del);
      if (out_bad_char_seen !== want.bad)
        report_mismatch("bad_char_seen", out_bad_char_seen, want.bad);
    end
    results_seen++;
  endtask

  task automatic add_char(input logic [CHAR_W-1:0] ch, input logic [TARGET_W-1:0] target,
                          input logic last, input bit drain);
    cigar_req_t r;
    r.ch     = ch;
    r.target = target;
    r.last   = last;
    r.drain  = drain;
    pending_chars.insert(pending_chars.size(), r);
    total_items++;
    if (last) strings_sent++;
  endtask

  task automatic add_text(input string s, input logic [TARGET_W-1:0] target);
    int i;
    for (i = 0; i < s.len(); i++)
      add_char(s[i], target, i == s.len() - 1, 1'b0);
  endtask

  // Build one random string: mostly well-formed runs, some noise and cut-off runs
  task automatic gen_cigar(input bit drain);
    logic [CHAR_W-1:0]   text[$];
    logic [TARGET_W-1:0] tgt;
    int pick, n_ops, n_dig, k, j;
    pick = $urandom_range(0, 9);
    if (pick == 0) tgt = TARGET_W'($urandom);
    else if (pick == 1) tgt = $urandom_range(0, 1) ? '1 : '0;
    else tgt = TARGET_W'($urandom_range(0, 40));
    if ($urandom_range(0, 19) == 0) begin
      n_ops = $urandom_range(1, 5);
      for (k = 0; k < n_ops; k++) text.insert(text.size(), CHAR_W'($urandom_range(0, 255)));
    end else begin
      n_ops = $urandom_range(1, 6);
      for (k = 0; k < n_ops; k++) begin
        n_dig = ($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, 2);
        for (j = 0; j < n_dig; j++)
          text.insert(text.size(), CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 14) == 0)
          text.insert(text.size(), CHAR_W'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: text.insert(text.size(), CH_SOFT);
          1: text.insert(text.size(), CH_MAT);
          2: text.insert(text.size(), CH_DEL);
          default: text.insert(text.size(), CH_INS);
        endcase
      end
      if ($urandom_range(0, 9) == 0)
        text.insert(text.size(), CHAR_W'(CH_ZERO + $urandom_range(1, 9)));
    end
    for (j = 0; j < text.size(); j++)
      add_char(text[j], tgt, j == text.size() - 1, drain && j == 0);
  endtask

  // Sample both handshakes and run the prediction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      walk_char(offered);
      req_taken = 1'b1;
      accepted_cnt++;
    end
    if (rst_n && out_valid && out_ready) check_result();
  end

  // Drive character requests; hold each until taken
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !req_taken)) begin
      req_taken = 1'b0;
      if (pending_chars.size() != 0
          && !(pending_chars[0].drain && expected_results.size() != 0)
          && ((accepted_cnt >= 700 && accepted_cnt < 1100)
              || $urandom_range(0, 99) >= IDLE_PCT)) begin
        offered = pending_chars.pop_front();
        in_valid         <= 1'b1;
        in_cigar_char    <= offered.ch;
        in_target_offset <= offered.target;
        in_last_char     <= offered.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive result ready with random stalls and two long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && hold_starts < 2
          && results_seen >= (hold_starts == 0 ? 25 : 140)) begin
        hold_left = HOLD_CYCLES;
        hold_starts++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 70 && results_seen < 120) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES,
             expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int n;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cigar_char    = '0;
    in_target_offset = '0;
    in_last_char     = 1'b0;
    out_ready        = 1'b0;
    req_taken        = 1'b0;
    run_len = '0; match_tot = '0; del_tot = '0; ins_tot = '0;
    walk_stopped = 1'b0; walk_on_del = 1'b0; walk_bad = 1'b0;

    // Directed strings: target never reached, stop in a deletion, bare letter,
    // unknown characters, characters after the stop, saturated run
    add_text("3S4M2I", 20'd100);
    add_text("2M3D1M", 20'd4);
    add_text("M", 20'd0);
    add_char("2", 20'hFFFFF, 1'b0, 1'b0);
    add_char(8'hFF, 20'hFFFFF, 1'b0, 1'b0);
    add_char(CH_INS, 20'hFFFFF, 1'b0, 1'b0);
    add_char(8'h00, 20'hFFFFF, 1'b1, 1'b0);
    add_text("1M?", 20'd1);
    add_text("9999999I", 20'd0);

    // Random strings; pause the sender for a full drain twice
    n = 0;
    while (total_items < 2025) begin
      gen_cigar(n == 40 || n == 150);
      n++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (accepted_cnt == total_items);
    wait (expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("walked %0d strings in %0d characters, checked %0d results", strings_sent,
             total_items, results_seen);
    $display("stops in a deletion %0d, strings with bad characters %0d, saturated runs %0d",
             del_hits, bad_hits, sat_runs);
    if (error_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
